>>> hdl/fbrgb_pkg.sv
// fbrgb_pkg: types, codes and helpers shared by the frame-buffer pixel unpacker
// no dependencies; compile first
package fbrgb_pkg;

   localparam int PAL_DEPTH      = 256;
   localparam int PAL_AW         = $clog2(PAL_DEPTH);
   localparam int MAX_LINE_WIDTH = 2048;
   localparam int CSR_DATA_W     = 12;

   typedef logic [2:0]            depth_code_type;
   typedef logic [1:0]            csr_index_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [11:0]           width_type;
   typedef logic [10:0]           column_type;
   typedef logic [15:0]           rgb565_type;
   typedef logic [31:0]           pixel_type;

   // depth codes
   localparam depth_code_type DEPTH_1BPP   = 3'd0;
   localparam depth_code_type DEPTH_2BPP   = 3'd1;
   localparam depth_code_type DEPTH_4BPP   = 3'd2;
   localparam depth_code_type DEPTH_8BPP   = 3'd3;
   localparam depth_code_type DEPTH_16BPP  = 3'd4;
   localparam depth_code_type DEPTH_24BPP  = 3'd5;
   localparam depth_code_type DEPTH_32BPP  = 3'd6;
   localparam depth_code_type DEPTH_32BPPX = 3'd7;

   // register indexes
   localparam csr_index_type CSR_PIXEL_SIZE  = 2'd0;
   localparam csr_index_type CSR_PIXEL_ORDER = 2'd1;
   localparam csr_index_type CSR_LINE_WIDTH  = 2'd2;

   // beat kinds
   localparam logic MODE_PIXELS  = 1'b0;
   localparam logic MODE_PALETTE = 1'b1;

   localparam width_type LINE_WIDTH_RESET = 12'd480;

   function automatic logic [23:0] widen565(input rgb565_type v);
      logic [4:0] r;
      logic [5:0] g;
      logic [4:0] b;
      r = v[15:11];
      g = v[10:5];
      b = v[4:0];
      return {r, r[4:2], g, g[5:4], b, b[4:2]};
   endfunction

endpackage

>>> hdl/fbrgb_if.sv
// fbrgb_if: valid/ready channels for frame-buffer beats and pixel results
// depends on fbrgb_pkg
interface fbrgb_req_if;
   import fbrgb_pkg::*;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [31:0] data_word;
   logic [7:0] palette_index;
   rgb565_type palette_value;

   modport source (output valid, mode, data_word, palette_index, palette_value,
                   input ready);
   modport sink (input valid, mode, data_word, palette_index, palette_value,
                 output ready);
endinterface

interface fbrgb_rsp_if;
   import fbrgb_pkg::*;
   logic       valid;
   logic       ready;
   pixel_type  pixel_rgb;
   column_type pixel_column;
   logic       end_of_line;
   logic       last_of_item;

   modport source (output valid, pixel_rgb, pixel_column, end_of_line, last_of_item,
                   input ready);
   modport sink (input valid, pixel_rgb, pixel_column, end_of_line, last_of_item,
                 output ready);
endinterface

>>> hdl/fbrgb_ram.sv
// fbrgb_ram: generic single-write, single-read ram with registered read-first output
// no dependencies
module fbrgb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/framebuffer_word_to_rgb_pixels.sv
// framebuffer_word_to_rgb_pixels: frame-buffer word to xRGB pixel unpacker, top level
// depends on fbrgb_pkg, fbrgb_if and fbrgb_ram
//
// One pixel leaves per clock while the pixel side is ready. A beat holds the unpack stage
// until its last pixel moves on, and the next beat is taken in that cycle, so at 32bpp a
// beat enters every cycle while the pixel side is ready. A beat yields 1 pixel at 32bpp,
// 2 at 16bpp, 1 or 2 at 24bpp, 32/bpp at indexed depths, fewer where the line ends inside
// the word. A palette write gives no pixel. A beat passes the unpack and result registers;
// the palette ram read sits in the result stage. Per-entry valid bits clear the palette at
// reset, so no clearing pass is needed and beats are taken straight after reset.
module framebuffer_word_to_rgb_pixels (
   input  logic                     clock,
   input  logic                     reset,
   fbrgb_req_if.sink                req_bus,
   fbrgb_rsp_if.source              rsp_bus,
   input  logic                     csr_wr_en,
   input  fbrgb_pkg::csr_index_type csr_index,
   input  fbrgb_pkg::csr_data_type  csr_wr_data
);
   import fbrgb_pkg::*;

   // configuration
   depth_code_type size_code_ff, size_code_in;
   logic           little_order_ff, little_order_in;
   width_type      line_width_ff, line_width_in;

   // unpack stage
   logic           a_valid_ff, a_valid_in;
   logic [47:0]    a_buf_ff, a_buf_in;
   logic [4:0]     a_k_ff, a_k_in;
   logic [5:0]     a_count_ff, a_count_in;
   logic [1:0]     a_left_ff, a_left_in;
   column_type     column_ff, column_in;
   logic [15:0]    carry_bytes_ff, carry_bytes_in;
   logic [1:0]     carry_count_ff, carry_count_in;

   // result stage
   logic           b_valid_ff, b_valid_in;
   logic           b_is_pal_ff, b_is_pal_in;
   logic           b_pal_ok_ff, b_pal_ok_in;
   pixel_type      b_pix_ff, b_pix_in;
   column_type     b_column_ff, b_column_in;
   logic           b_eol_ff, b_eol_in;
   logic           b_last_ff, b_last_in;

   logic [PAL_DEPTH-1:0] pal_valid_ff, pal_valid_in;

   width_type      wid;
   width_type      col_inc;
   column_type     col_after, col_src, col_start;
   logic           a_last, a_eol, a_move, a_done;
   logic           accept, load, pal_wr, stale, use_carry;
   logic [15:0]    carry_new, carry_src, cb_start;
   logic [1:0]     count_new, count_src, cc_start;
   logic [47:0]    buf24;
   logic [31:0]    a_word, shifted;
   logic [5:0]     sh_amt;
   logic [7:0]     idx_mask, a_idx;
   logic           a_idx_ok, wr_idx_ok;
   logic [5:0]     load_count;
   logic [1:0]     load_left;
   pixel_type      a_pix;
   logic           a_is_pal;
   rgb565_type     pal_rd_data;

   always_comb begin
      size_code_in    = size_code_ff;
      little_order_in = little_order_ff;
      line_width_in   = line_width_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PIXEL_SIZE:  size_code_in    = csr_wr_data[2:0];
            CSR_PIXEL_ORDER: little_order_in = csr_wr_data[0];
            CSR_LINE_WIDTH:  line_width_in   = csr_wr_data[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      // clamped line width
      if (line_width_ff < 12'd2) begin
         wid = 12'd2;
      end else if (line_width_ff > 12'(MAX_LINE_WIDTH)) begin
         wid = 12'(MAX_LINE_WIDTH);
      end else begin
         wid = line_width_ff;
      end

      a_word    = a_buf_ff[31:0];
      a_last    = ({1'b0, a_k_ff} == (a_count_ff - 6'd1));
      col_inc   = {1'b0, column_ff} + 12'd1;
      a_eol     = (col_inc >= wid);
      col_after = a_eol ? '0 : col_inc[10:0];
      a_move    = a_valid_ff && (!b_valid_ff || rsp_bus.ready);
      a_done    = a_move && (a_last || a_eol);

      req_bus.ready = !a_valid_ff || a_done;
      accept = req_bus.valid && req_bus.ready;
      load   = accept && (req_bus.mode == MODE_PIXELS);
      pal_wr = accept && (req_bus.mode == MODE_PALETTE);

      // bytes held over from the word now finishing
      carry_new = '0;
      count_new = '0;
      if (!a_eol) begin
         count_new = a_left_ff;
         case (a_left_ff)
            2'd1:    carry_new = {8'h00, a_buf_ff[31:24]};
            2'd2:    carry_new = a_buf_ff[39:24];
            default: carry_new = '0;
         endcase
      end

      col_src   = a_move ? col_after : column_ff;
      carry_src = a_done ? carry_new : carry_bytes_ff;
      count_src = a_done ? count_new : carry_count_ff;
      stale     = ({1'b0, col_src} >= wid);
      col_start = stale ? '0 : col_src;
      use_carry = !stale && (size_code_ff == DEPTH_24BPP);
      cb_start  = use_carry ? carry_src : '0;
      cc_start  = use_carry ? count_src : '0;
      buf24     = (48'(req_bus.data_word) << {cc_start, 3'b000}) | 48'(cb_start);

      load_left = '0;
      unique case (size_code_ff)
         DEPTH_1BPP:  load_count = 6'd32;
         DEPTH_2BPP:  load_count = 6'd16;
         DEPTH_4BPP:  load_count = 6'd8;
         DEPTH_8BPP:  load_count = 6'd4;
         DEPTH_16BPP: load_count = 6'd2;
         DEPTH_24BPP: begin
            load_count = (cc_start == 2'd2) ? 6'd2 : 6'd1;
            case (cc_start)
               2'd0:    load_left = 2'd1;
               2'd1:    load_left = 2'd2;
               default: load_left = 2'd0;
            endcase
         end
         default:     load_count = 6'd1;
      endcase

      // palette index of the current pixel
      if (little_order_ff) begin
         sh_amt = 6'(a_k_ff) << size_code_ff[1:0];
      end else begin
         sh_amt = 6'd32 - ((6'(a_k_ff) + 6'd1) << size_code_ff[1:0]);
      end
      shifted = a_word >> sh_amt;
      unique case (size_code_ff[1:0])
         2'd0:    idx_mask = 8'h01;
         2'd1:    idx_mask = 8'h03;
         2'd2:    idx_mask = 8'h0f;
         default: idx_mask = 8'hff;
      endcase
      a_idx    = shifted[7:0] & idx_mask;
      a_idx_ok = (9'(a_idx) < 9'(PAL_DEPTH));

      a_is_pal = 1'b0;
      unique case (size_code_ff) inside
         DEPTH_1BPP, DEPTH_2BPP, DEPTH_4BPP, DEPTH_8BPP: begin
            a_is_pal = 1'b1;
            a_pix    = '0;
         end
         DEPTH_16BPP: a_pix = {8'h00, widen565(a_k_ff[0] ? a_word[31:16] : a_word[15:0])};
         DEPTH_24BPP: a_pix = {8'h00, (a_k_ff[0] ? a_buf_ff[47:24] : a_buf_ff[23:0])};
         default:     a_pix = a_word;
      endcase

      wr_idx_ok = (9'(req_bus.palette_index) < 9'(PAL_DEPTH));
   end

   always_comb begin
      a_valid_in     = a_valid_ff;
      a_buf_in       = a_buf_ff;
      a_k_in         = a_k_ff;
      a_count_in     = a_count_ff;
      a_left_in      = a_left_ff;
      column_in      = column_ff;
      carry_bytes_in = carry_bytes_ff;
      carry_count_in = carry_count_ff;
      pal_valid_in   = pal_valid_ff;

      if (a_move) begin
         column_in = col_after;
         a_k_in    = a_k_ff + 5'd1;
      end
      if (a_done) begin
         a_valid_in     = 1'b0;
         carry_bytes_in = carry_new;
         carry_count_in = count_new;
      end
      if (load) begin
         a_valid_in = 1'b1;
         a_k_in     = '0;
         column_in  = col_start;
         a_count_in = load_count;
         a_left_in  = load_left;
         a_buf_in   = (size_code_ff == DEPTH_24BPP) ? buf24 : 48'(req_bus.data_word);
      end
      if (pal_wr && wr_idx_ok) begin
         pal_valid_in[req_bus.palette_index[PAL_AW-1:0]] = 1'b1;
      end

      b_valid_in  = b_valid_ff;
      b_is_pal_in = b_is_pal_ff;
      b_pal_ok_in = b_pal_ok_ff;
      b_pix_in    = b_pix_ff;
      b_column_in = b_column_ff;
      b_eol_in    = b_eol_ff;
      b_last_in   = b_last_ff;
      if (a_move) begin
         b_valid_in  = 1'b1;
         b_is_pal_in = a_is_pal;
         b_pal_ok_in = a_idx_ok && pal_valid_ff[a_idx[PAL_AW-1:0]];
         b_pix_in    = a_pix;
         b_column_in = column_ff;
         b_eol_in    = a_eol;
         b_last_in   = a_last || a_eol;
      end else if (rsp_bus.ready) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_code_ff    <= DEPTH_1BPP;
         little_order_ff <= 1'b0;
         line_width_ff   <= LINE_WIDTH_RESET;
         a_valid_ff      <= 1'b0;
         b_valid_ff      <= 1'b0;
         column_ff       <= '0;
         carry_bytes_ff  <= '0;
         carry_count_ff  <= '0;
         pal_valid_ff    <= '0;
      end else begin
         size_code_ff    <= size_code_in;
         little_order_ff <= little_order_in;
         line_width_ff   <= line_width_in;
         a_valid_ff      <= a_valid_in;
         b_valid_ff      <= b_valid_in;
         column_ff       <= column_in;
         carry_bytes_ff  <= carry_bytes_in;
         carry_count_ff  <= carry_count_in;
         pal_valid_ff    <= pal_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_buf_ff    <= a_buf_in;
      a_k_ff      <= a_k_in;
      a_count_ff  <= a_count_in;
      a_left_ff   <= a_left_in;
      b_is_pal_ff <= b_is_pal_in;
      b_pal_ok_ff <= b_pal_ok_in;
      b_pix_ff    <= b_pix_in;
      b_column_ff <= b_column_in;
      b_eol_ff    <= b_eol_in;
      b_last_ff   <= b_last_in;
   end

   fbrgb_ram #(
      .WIDTH (16),
      .DEPTH (PAL_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr && wr_idx_ok),
      .wr_addr (req_bus.palette_index[PAL_AW-1:0]),
      .wr_data (req_bus.palette_value),
      .rd_en   (a_move),
      .rd_addr (a_idx[PAL_AW-1:0]),
      .rd_data (pal_rd_data)
   );

   always_comb begin
      rsp_bus.valid        = b_valid_ff;
      rsp_bus.pixel_column = b_column_ff;
      rsp_bus.end_of_line  = b_eol_ff;
      rsp_bus.last_of_item = b_last_ff;
      if (b_is_pal_ff) begin
         rsp_bus.pixel_rgb = b_pal_ok_ff ? {8'h00, widen565(pal_rd_data)} : '0;
      end else begin
         rsp_bus.pixel_rgb = b_pix_ff;
      end
   end

endmodule

>>> dv/framebuffer_word_to_rgb_pixels_tb.sv
// framebuffer_word_to_rgb_pixels_tb: self-checking bench for the frame-buffer pixel unpacker
// drives words and palette writes with bursty valid, stalls the pixel side and checks pixels
// depends on fbrgb_pkg, fbrgb_if and the framebuffer_word_to_rgb_pixels rtl
module framebuffer_word_to_rgb_pixels_tb;
   import fbrgb_pkg::*;

   typedef struct {
      pixel_type  rgb;
      column_type column;
      logic       eol;
      logic       last_of_item;
   } pixel_expect_type;

   class pixel_scoreboard;
      rgb565_type       palette [PAL_DEPTH];
      int unsigned      column;
      logic [15:0]      carry_bytes;
      int unsigned      carry_count;
      depth_code_type   depth;
      logic             little_order;
      width_type        line_width;
      bit               line_done;
      pixel_expect_type pixels_due [$];
      int               errors, beats, palette_writes, pixels_checked;

      function new();
         for (int i = 0; i < PAL_DEPTH; i++) palette[i] = '0;
         column = 0;
         carry_bytes = '0;
         carry_count = 0;
         depth = DEPTH_1BPP;
         little_order = 1'b0;
         line_width = LINE_WIDTH_RESET;
         errors = 0;
         beats = 0;
         palette_writes = 0;
         pixels_checked = 0;
      endfunction

      function void set_reg(csr_index_type idx, csr_data_type d);
         case (idx)
            CSR_PIXEL_SIZE:  depth = d[2:0];
            CSR_PIXEL_ORDER: little_order = d[0];
            CSR_LINE_WIDTH:  line_width = d;
            default: ;
         endcase
      endfunction

      function int unsigned bits_per_pixel(depth_code_type c);
         case (c)
            DEPTH_1BPP:  return 1;
            DEPTH_2BPP:  return 2;
            DEPTH_4BPP:  return 4;
            DEPTH_8BPP:  return 8;
            DEPTH_16BPP: return 16;
            DEPTH_24BPP: return 24;
            default:     return 32;
         endcase
      endfunction

      function pixel_type expand565(rgb565_type v);
         int unsigned r, g, b;
         r = (v >> 11) & 'h1f;
         g = (v >> 5) & 'h3f;
         b = v & 'h1f;
         return pixel_type'(((r * 8 + r / 4) << 16) | ((g * 4 + g / 16) << 8) | (b * 8 + b / 4));
      endfunction

      function void push_pixel(pixel_type rgb, int unsigned wid);
         pixel_expect_type e;
         e.rgb = rgb;
         e.column = column_type'(column);
         e.eol = (column + 1 >= wid);
         e.last_of_item = 1'b0;
         pixels_due.push_back(e);
         column++;
         if (column >= wid) begin
            column = 0;
            line_done = 1'b1;
         end
      endfunction

      function void note_beat(logic mode, logic [31:0] word, logic [7:0] pidx,
                              rgb565_type pval);
         int unsigned bpp, wid, nb, i, k, per, sh;
         logic [7:0]  octets [6];
         logic [7:0]  pal_idx;
         beats++;
         if (mode == MODE_PALETTE) begin
            palette[pidx] = pval;
            palette_writes++;
            return;
         end
         bpp = bits_per_pixel(depth);
         wid = line_width;
         if (wid < 2) wid = 2;
         if (wid > MAX_LINE_WIDTH) wid = MAX_LINE_WIDTH;
         if (column >= wid) begin
            column = 0;
            carry_count = 0;
            carry_bytes = '0;
         end
         line_done = 1'b0;
         if (bpp == 24) begin
            nb = (carry_count > 2) ? 2 : carry_count;
            for (i = 0; i < nb; i++) octets[i] = carry_bytes[8*i +: 8];
            for (k = 0; k < 4; k++) octets[nb+k] = word[8*k +: 8];
            nb += 4;
            i = 0;
            while (nb - i >= 3 && !line_done) begin
               push_pixel({8'h00, octets[i+2], octets[i+1], octets[i]}, wid);
               i += 3;
            end
            carry_count = 0;
            carry_bytes = '0;
            if (!line_done) begin
               carry_count = nb - i;
               for (k = 0; k < carry_count; k++) carry_bytes[8*k +: 8] = octets[i+k];
            end
         end else begin
            carry_count = 0;
            carry_bytes = '0;
            if (bpp == 32) begin
               push_pixel(word, wid);
            end else if (bpp == 16) begin
               push_pixel(expand565(word[15:0]), wid);
               if (!line_done) push_pixel(expand565(word[31:16]), wid);
            end else begin
               per = 32 / bpp;
               for (k = 0; k < per && !line_done; k++) begin
                  sh = little_order ? k * bpp : 32 - bpp - k * bpp;
                  pal_idx = 8'((word >> sh) & ((1 << bpp) - 1));
                  push_pixel(expand565(palette[pal_idx]), wid);
               end
            end
         end
         pixels_due[pixels_due.size()-1].last_of_item = 1'b1;
      endfunction

      function void check_pixel(pixel_type rgb, column_type col, logic eol, logic last);
         pixel_expect_type e;
         if (pixels_due.size() == 0) begin
            $error("pixel with nothing expected: rgb %h column %0d", rgb, col);
            errors++;
            return;
         end
         e = pixels_due.pop_front();
         pixels_checked++;
         if (rgb !== e.rgb) begin
            $error("pixel_rgb: expected %h, got %h", e.rgb, rgb);
            errors++;
         end
         if (col !== e.column) begin
            $error("pixel_column: expected %0d, got %0d", e.column, col);
            errors++;
         end
         if (eol !== e.eol) begin
            $error("end_of_line: expected %b, got %b", e.eol, eol);
            errors++;
         end
         if (last !== e.last_of_item) begin
            $error("last_of_item: expected %b, got %b", e.last_of_item, last);
            errors++;
         end
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            csr_wr_en;
   csr_index_type   csr_index;
   csr_data_type    csr_wr_data;
   fbrgb_req_if     req_bus();
   fbrgb_rsp_if     rsp_bus();
   pixel_scoreboard sb;
   int              burst_left;
   int              settings_used;

   framebuffer_word_to_rgb_pixels dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #4_000_000;
      $display("framebuffer_word_to_rgb_pixels_tb: done, errors");
      $finish;
   end

   // pixel-side stall pattern, its style picked at random
   initial begin
      int cyc;
      int style;
      int hold;
      cyc = 0;
      style = 0;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (cyc % 48 == 0) style = $urandom_range(0, 3);
         cyc++;
         case (style)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 9) < 7);
            2: rsp_bus.ready <= (cyc % 4 == 0);
            default: begin
               if (hold > 0) begin
                  hold--;
                  rsp_bus.ready <= 1'b0;
               end else begin
                  rsp_bus.ready <= 1'b1;
                  if ($urandom_range(0, 3) == 0) hold = $urandom_range(1, 8);
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         sb.check_pixel(rsp_bus.pixel_rgb, rsp_bus.pixel_column, rsp_bus.end_of_line,
                        rsp_bus.last_of_item);
   end

   task automatic send_beat(input logic mode, input logic [31:0] word,
                            input logic [7:0] pidx, input rgb565_type pval);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_bus.valid         <= 1'b1;
      req_bus.mode          <= mode;
      req_bus.data_word     <= word;
      req_bus.palette_index <= pidx;
      req_bus.palette_value <= pval;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_beat(mode, word, pidx, pval);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (sb.pixels_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input depth_code_type code, input logic little,
                            input width_type wid);
      csr_data_type d;
      d = csr_data_type'($urandom);
      d[2:0] = code;
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_PIXEL_SIZE;
      csr_wr_data <= d;
      @(posedge clock);
      sb.set_reg(CSR_PIXEL_SIZE, d);
      d = csr_data_type'($urandom);
      d[0] = little;
      csr_index   <= CSR_PIXEL_ORDER;
      csr_wr_data <= d;
      @(posedge clock);
      sb.set_reg(CSR_PIXEL_ORDER, d);
      csr_index   <= CSR_LINE_WIDTH;
      csr_wr_data <= wid;
      @(posedge clock);
      sb.set_reg(CSR_LINE_WIDTH, wid);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   initial begin
      width_type   wid;
      logic [31:0] word;
      sb = new();
      burst_left = 0;
      settings_used = 1;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_PIXEL_SIZE;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_PIXELS;
      req_bus.data_word = '0;
      req_bus.palette_index = '0;
      req_bus.palette_value = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 1bpp msb first, palette still clear
      send_beat(MODE_PIXELS, 32'hA5A5_0F0F, 8'h00, 16'h0000);
      send_beat(MODE_PALETTE, 32'h0, 8'd0, 16'hF800);
      send_beat(MODE_PALETTE, 32'h0, 8'd1, 16'h07E0);
      send_beat(MODE_PALETTE, 32'h0, 8'd2, 16'h001F);
      send_beat(MODE_PALETTE, 32'h0, 8'd3, 16'hFFFF);
      send_beat(MODE_PALETTE, 32'h0, 8'd255, 16'hFFFF);
      send_beat(MODE_PALETTE, 32'h0, 8'd128, 16'h8410);
      send_beat(MODE_PIXELS, 32'h8000_0001, 8'hFF, 16'hFFFF);
      settle();
      configure(DEPTH_2BPP, 1'b1, 12'd480);
      send_beat(MODE_PIXELS, 32'hE4E4_1B1B, 8'h00, 16'h0000);
      settle();
      configure(DEPTH_4BPP, 1'b0, 12'd480);
      send_beat(MODE_PIXELS, 32'hFEDC_BA98, 8'h00, 16'h0000);
      settle();
      // line ends inside a word
      configure(DEPTH_8BPP, 1'b1, 12'd6);
      send_beat(MODE_PIXELS, 32'h80FF_0203, 8'h00, 16'h0000);
      send_beat(MODE_PIXELS, 32'h0001_0203, 8'h00, 16'h0000);
      settle();
      configure(DEPTH_16BPP, 1'b0, 12'd3);
      send_beat(MODE_PIXELS, 32'hFFFF_0000, 8'h00, 16'h0000);
      send_beat(MODE_PIXELS, 32'h1234_ABCD, 8'h00, 16'h0000);
      send_beat(MODE_PIXELS, 32'h8410_07E0, 8'h00, 16'h0000);
      settle();
      // 24bpp bytes held over across words, then dropped at a depth change
      configure(DEPTH_24BPP, 1'b0, 12'd5);
      send_beat(MODE_PIXELS, 32'h3322_1100, 8'h00, 16'h0000);
      send_beat(MODE_PIXELS, 32'h7766_5544, 8'h00, 16'h0000);
      send_beat(MODE_PIXELS, 32'hBBAA_9988, 8'h00, 16'h0000);
      send_beat(MODE_PIXELS, 32'hFFEE_DDCC, 8'h00, 16'h0000);
      send_beat(MODE_PIXELS, 32'h0102_0304, 8'h00, 16'h0000);
      settle();
      configure(DEPTH_32BPP, 1'b0, 12'd2);
      send_beat(MODE_PIXELS, 32'hFFFF_FFFF, 8'h00, 16'h0000);
      send_beat(MODE_PIXELS, 32'h0000_0000, 8'h00, 16'h0000);
      settle();
      configure(DEPTH_32BPPX, 1'b1, 12'd2048);
      send_beat(MODE_PIXELS, 32'h8000_0001, 8'h00, 16'h0000);
      settle();
      // width lowered mid-line, then below and above its range
      configure(DEPTH_8BPP, 1'b0, 12'd2048);
      send_beat(MODE_PIXELS, 32'h0380_FF01, 8'h00, 16'h0000);
      settle();
      configure(DEPTH_8BPP, 1'b0, 12'd0);
      send_beat(MODE_PIXELS, 32'h0201_0380, 8'h00, 16'h0000);
      settle();
      configure(DEPTH_32BPP, 1'b1, 12'd4095);
      send_beat(MODE_PIXELS, 32'h5A5A_A5A5, 8'h00, 16'h0000);
      settle();

      for (int ph = 0; ph < 8; ph++) begin
         case ($urandom_range(0, 9))
            0: wid = width_type'($urandom_range(0, 1));
            1: wid = 12'd2;
            2: wid = 12'd2048;
            3: wid = width_type'($urandom_range(2049, 4095));
            4: wid = width_type'($urandom_range(2, 2048));
            default: wid = width_type'($urandom_range(3, 40));
         endcase
         configure(depth_code_type'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), wid);
         repeat ($urandom_range(10, 20)) begin
            case ($urandom_range(0, 7))
               0: word = 32'h0000_0000;
               1: word = 32'hFFFF_FFFF;
               default: word = $urandom;
            endcase
            if ($urandom_range(0, 4) == 0)
               send_beat(MODE_PALETTE, word, 8'($urandom), rgb565_type'($urandom));
            else
               send_beat(MODE_PIXELS, word, 8'($urandom), rgb565_type'($urandom));
         end
         settle();
      end

      repeat (8) @(posedge clock);
      $display("%0d beats (%0d palette writes) over %0d register settings, %0d pixels checked",
               sb.beats, sb.palette_writes, settings_used, sb.pixels_checked);
      if (sb.errors == 0 && sb.pixels_due.size() == 0)
         $display("framebuffer_word_to_rgb_pixels_tb: done, clean");
      else
         $display("framebuffer_word_to_rgb_pixels_tb: done, errors");
      $finish;
   end

endmodule

>>> filelist.f
hdl/fbrgb_pkg.sv
hdl/fbrgb_if.sv
hdl/fbrgb_ram.sv
hdl/framebuffer_word_to_rgb_pixels.sv
dv/framebuffer_word_to_rgb_pixels_tb.sv
